// ===== hdl/eqfe_pkg.sv =====
// Shared types, constants and helpers for the eigen quadratic form engine.
// No dependencies; imported by every other file except eqfe_ram.
`default_nettype none
package eqfe_pkg;
  localparam int MAX_SIZE  = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int CNT_W     = $clog2(MAX_SIZE + 1);
  localparam int DRAIN_CYC = MAX_SIZE + 4;

  localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] OP_DATA        = 2'd2;

  localparam logic CFG_RESULT_MODE = 1'b0;
  localparam logic CFG_SIZE_IN_USE = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         row_index;
    logic [3:0]         column_index;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [3:0]         result_index;
    logic               result_last;
  } out_item_t;

  // data element travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   row;
    logic signed [31:0] x;
    logic [CNT_W-1:0]   n;
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               clear;
    logic               fin;
    logic [IDX_W-1:0]   rd_row;
    logic               ld_en;
    logic [IDX_W-1:0]   ld_row;
    logic [IDX_W-1:0]   ld_col;
    logic signed [31:0] ld_data;
    logic               acc_we;
    logic [IDX_W-1:0]   acc_sel;
    logic signed [63:0] acc_data;
  } ctl_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== hdl/eigen_quadratic_form_engine.sv =====
// Top level of the eigen quadratic form engine: command port, config port,
// cell chain, shared Q multiplier and finish sequencer. Uses eqfe_pkg.
//
// Usage: write result_mode and size_in_use through the cfg port (always
// ready). Load V entries (op 0) and weights (op 1); a load never raises
// busy. Feed data elements (op 2): each holds busy while it ripples down
// the row of MAX_SIZE cells, one cell per cycle, each cell doing one RAM
// read and one 32x32 multiply-accumulate. After the element marked last
// the sequencer runs every result through one shared multiplier; quadratic
// mode gives one beat, vector mode N beats. Each result beat appears on
// result for exactly one cycle with result_valid high; the receiver cannot
// stall, so sample it then. Results saturate to the signed 64-bit range.
`default_nettype none
module eigen_quadratic_form_engine import eqfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   cmd,
  output logic            result_valid,
  output out_item_t       result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DRAIN  = 4'd1;
  localparam logic [3:0] S_M_GO   = 4'd2;
  localparam logic [3:0] S_M_WAIT = 4'd3;
  localparam logic [3:0] S_Q_GO   = 4'd4;
  localparam logic [3:0] S_Q_WAIT = 4'd5;
  localparam logic [3:0] S_V_RD   = 4'd6;
  localparam logic [3:0] S_V_GO   = 4'd7;
  localparam logic [3:0] S_V_WAIT = 4'd8;

  logic [3:0]         state;
  logic               result_mode;
  logic [4:0]         size_in_use;
  logic [CNT_W-1:0]   n_act, n_run;
  logic [CNT_W-1:0]   j, i;
  logic [4:0]         drain;
  logic               last_pend;
  logic               mode_run;
  logic signed [63:0] total, m, tsum;
  logic [IDX_W-1:0]   rd_row;
  logic [31:0]        weight [MAX_SIZE];
  tok_t               tok0;
  ctl_t               ctl;
  logic               accept;
  logic               q_start, q_done;
  logic signed [63:0] q_a, q_b, q_y;

  tok_t               chain   [MAX_SIZE+1];
  logic signed [31:0] rd_bus  [MAX_SIZE];
  logic signed [63:0] acc_bus [MAX_SIZE];

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;

  // size 0 acts as 1, anything above MAX_SIZE as MAX_SIZE
  always_comb begin
    if (size_in_use == 5'd0) begin
      n_act = CNT_W'(1);
    end else if (32'(size_in_use) > MAX_SIZE) begin
      n_act = CNT_W'(MAX_SIZE);
    end else begin
      n_act = CNT_W'(size_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_mode <= 1'b0;
      size_in_use <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RESULT_MODE: result_mode <= cfg_data[0];
        CFG_SIZE_IN_USE: size_in_use <= cfg_data;
        default:         ;
      endcase
    end
  end

  // weight store: one read port driven by the sequencer index
  always_ff @(posedge clk) begin
    if (accept && cmd.op == OP_LOAD_WEIGHT) begin
      weight[cmd.row_index] <= cmd.value;
    end
  end

  // inject a data beat into the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.valid <= 1'b0;
    end else begin
      tok0.valid <= accept && cmd.op == OP_DATA && ({1'b0, cmd.row_index} < n_act);
    end
    tok0.row <= cmd.row_index;
    tok0.x   <= cmd.value;
    tok0.n   <= n_act;
  end

  assign chain[0] = tok0;

  genvar g;
  generate
    for (g = 0; g < MAX_SIZE; g++) begin : g_cell
      eqfe_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .idx     (IDX_W'(g)),
        .ctl     (ctl),
        .tok_in  (chain[g]),
        .tok_out (chain[g+1]),
        .rd_data (rd_bus[g]),
        .acc     (acc_bus[g])
      );
    end
  endgenerate

  eqfe_qmul u_qmul (
    .clk   (clk),
    .rst   (rst),
    .start (q_start),
    .a     (q_a),
    .b     (q_b),
    .done  (q_done),
    .y     (q_y)
  );

  // operand select for the shared multiplier
  always_comb begin
    q_start = 1'b0;
    q_a     = 64'sd0;
    q_b     = 64'sd0;
    unique case (state)
      S_M_GO: begin
        q_start = 1'b1;
        q_a     = 64'($signed(weight[j[IDX_W-1:0]]));
        q_b     = acc_bus[j[IDX_W-1:0]];
      end
      S_Q_GO: begin
        q_start = 1'b1;
        q_a     = acc_bus[j[IDX_W-1:0]];
        q_b     = m;
      end
      S_V_GO: begin
        q_start = 1'b1;
        q_a     = 64'(rd_bus[j[IDX_W-1:0]]);
        q_b     = acc_bus[j[IDX_W-1:0]];
      end
      default: ;
    endcase
  end

  assign tsum = sat_add(total, q_y);

  always_comb begin
    ctl.fin      = state != S_IDLE && state != S_DRAIN;
    ctl.rd_row   = rd_row;
    ctl.ld_en    = accept && cmd.op == OP_LOAD_MATRIX;
    ctl.ld_row   = cmd.row_index;
    ctl.ld_col   = cmd.column_index;
    ctl.ld_data  = cmd.value;
    ctl.acc_we   = state == S_M_WAIT && q_done && mode_run;
    ctl.acc_sel  = j[IDX_W-1:0];
    ctl.acc_data = q_y;
    ctl.clear    = 1'b0;
    if (state == S_Q_WAIT && q_done && j + CNT_W'(1) == n_run) begin
      ctl.clear = 1'b1;
    end
    if (state == S_V_WAIT && q_done && j + CNT_W'(1) == n_run &&
        i + CNT_W'(1) == n_run) begin
      ctl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      last_pend    <= 1'b0;
      drain        <= 5'd0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.op == OP_DATA) begin
            state     <= S_DRAIN;
            drain     <= 5'(DRAIN_CYC);
            last_pend <= cmd.last;
            n_run     <= n_act;
            mode_run  <= result_mode;
          end
        end
        S_DRAIN: begin
          // hold until the beat has passed the last cell
          if (drain == 5'd0) begin
            state <= last_pend ? S_M_GO : S_IDLE;
            j     <= '0;
            i     <= '0;
            total <= 64'sd0;
          end else begin
            drain <= drain - 5'd1;
          end
        end
        S_M_GO: state <= S_M_WAIT;
        S_M_WAIT: begin
          if (q_done) begin
            m <= q_y;
            if (!mode_run) begin
              state <= S_Q_GO;
            end else if (j + CNT_W'(1) == n_run) begin
              j      <= '0;
              rd_row <= '0;
              state  <= S_V_RD;
            end else begin
              j     <= j + CNT_W'(1);
              state <= S_M_GO;
            end
          end
        end
        S_Q_GO: state <= S_Q_WAIT;
        S_Q_WAIT: begin
          if (q_done) begin
            if (j + CNT_W'(1) == n_run) begin
              result_valid        <= 1'b1;
              result.result_value <= tsum;
              result.result_index <= 4'd0;
              result.result_last  <= 1'b1;
              state               <= S_IDLE;
            end else begin
              total <= tsum;
              j     <= j + CNT_W'(1);
              state <= S_M_GO;
            end
          end
        end
        S_V_RD: state <= S_V_GO;
        S_V_GO: state <= S_V_WAIT;
        S_V_WAIT: begin
          if (q_done) begin
            if (j + CNT_W'(1) == n_run) begin
              result_valid        <= 1'b1;
              result.result_value <= tsum;
              result.result_index <= 4'(i);
              result.result_last  <= i + CNT_W'(1) == n_run;
              total               <= 64'sd0;
              j                   <= '0;
              if (i + CNT_W'(1) == n_run) begin
                state <= S_IDLE;
              end else begin
                i      <= i + CNT_W'(1);
                rd_row <= rd_row + IDX_W'(1);
                state  <= S_V_RD;
              end
            end else begin
              total <= tsum;
              j     <= j + CNT_W'(1);
              state <= S_V_GO;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/eqfe_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module eqfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/eqfe_qmul.sv =====
// Multi-cycle Q-format multiplier: 64x64 magnitude product from four 32x32
// partial products, floor shift by FRAC_BITS, saturation. Uses eqfe_pkg.
`default_nettype none
module eqfe_qmul import eqfe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      y
);
  localparam int TW = 128 - FRAC_BITS + 1;

  logic [63:0]  xm, ym;
  logic         neg;
  logic [2:0]   step;
  logic         run;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] prod;
  logic [31:0]  xs, ys;
  logic [6:0]   sh_now;
  logic [63:0]  qlo;
  logic         qhi_nz, rem;
  logic [TW-1:0] t;
  logic signed [63:0] fin;

  always_comb begin
    unique case (step)
      3'd1:    begin xs = xm[31:0];  ys = ym[31:0];  sh_now = 7'd0;  end
      3'd2:    begin xs = xm[31:0];  ys = ym[63:32]; sh_now = 7'd32; end
      3'd3:    begin xs = xm[63:32]; ys = ym[31:0];  sh_now = 7'd32; end
      3'd4:    begin xs = xm[63:32]; ys = ym[63:32]; sh_now = 7'd64; end
      default: begin xs = 32'd0;     ys = 32'd0;     sh_now = 7'd0;  end
    endcase
  end

  always_comb begin
    qlo    = prod[63+FRAC_BITS:FRAC_BITS];
    qhi_nz = |prod[127:64+FRAC_BITS];
    rem    = |prod[FRAC_BITS-1:0];
    t      = {1'b0, prod[127:FRAC_BITS]} + TW'(rem);
    if (!neg) begin
      fin = (qhi_nz || qlo[63]) ? {1'b0, {63{1'b1}}} : $signed(qlo);
    end else if (|t[TW-1:63]) begin
      fin = {1'b1, 63'd0};
    end else begin
      fin = -$signed(t[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= 3'd1;
      end else if (run) begin
        if (step == 3'd6) begin
          run  <= 1'b0;
          done <= 1'b1;
          step <= 3'd0;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xm   <= a[63] ? 64'd0 - 64'(a) : 64'(a);
      ym   <= b[63] ? 64'd0 - 64'(b) : 64'(b);
      neg  <= a[63] != b[63];
      prod <= 128'd0;
    end else if (run) begin
      pp    <= 64'(xs) * 64'(ys);
      pp_sh <= sh_now;
      if (step >= 3'd2 && step <= 3'd5) begin
        prod <= prod + (128'(pp) << pp_sh);
      end
      if (step == 3'd6) begin
        y <= fin;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/eqfe_cell.sv =====
// One chain cell: holds matrix column j and projection accumulator r_j,
// multiplies the passing data element and hands it on. Uses eqfe_pkg, eqfe_ram.
`default_nettype none
module eqfe_cell import eqfe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [IDX_W-1:0]   idx,
  input  wire ctl_t               ctl,
  input  wire tok_t               tok_in,
  output tok_t                    tok_out,
  output logic signed [31:0]      rd_data,
  output logic signed [63:0]      acc
);
  tok_t               tok1;
  logic               en2;
  logic signed [63:0] prod;
  logic [31:0]        ram_q;

  eqfe_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_col (
    .clk   (clk),
    .we    (ctl.ld_en && ctl.ld_col == idx),
    .waddr (ctl.ld_row),
    .wdata (ctl.ld_data),
    .raddr (ctl.fin ? ctl.rd_row : tok_in.row),
    .rdata (ram_q)
  );

  assign rd_data = $signed(ram_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      tok1.valid    <= 1'b0;
      en2           <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok1.valid    <= tok_in.valid;
      en2           <= tok1.valid && ({1'b0, idx} < tok1.n);
    end
  end

  always_ff @(posedge clk) begin
    tok_out.row <= tok_in.row;
    tok_out.x   <= tok_in.x;
    tok_out.n   <= tok_in.n;
    tok1.row    <= tok_in.row;
    tok1.x      <= tok_in.x;
    tok1.n      <= tok_in.n;
    prod        <= rd_data * tok1.x;
  end

  // clear wins over a write-back, which wins over accumulation
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= 64'sd0;
    end else if (ctl.acc_we && ctl.acc_sel == idx) begin
      acc <= ctl.acc_data;
    end else if (en2) begin
      acc <= sat_add(acc, prod >>> FRAC_BITS);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/eqfe_checker.sv =====
// Port-level checker for the eigen quadratic form engine, bound to the top.
// Uses eqfe_pkg.
`default_nettype none
module eqfe_checker import eqfe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  cmd,
  input wire logic      result_valid,
  input wire out_item_t result
);
  // every result beat takes at least one multiplier pass, so beats never abut
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result beats back to back");

  // a data beat always occupies the block
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.op == OP_DATA |=> busy) else $error("data beat not busy");

  // more results follow a non-final beat, so the block stays busy
  a_more: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.result_last |-> busy) else $error("run ended early");

  // a load never produces a result next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.op != OP_DATA |=> !result_valid) else $error("load gave result");
endmodule

bind eigen_quadratic_form_engine eqfe_checker u_eqfe_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);
`default_nettype wire
